### rtl/rswkr_pkg.sv
// Shared types, codes and defaults for the record stack with key removal.
package rswkr_pkg;

    localparam int DEPTH_DEF         = 64;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam int FIELD_W     = 32;
    localparam int OCC_W       = 7;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 80;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_REMOVE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    push;
        logic    rd_top;
        logic    take_top;
        logic    walk_start;
        logic    walk_step;
        logic    walk_end;
        logic    res_init;
        status_t res_code;
        logic    out_load;
    } rswkr_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    empty;
        logic    walk_done;
        logic    out_free;
    } rswkr_sts_t;

endpackage

### rtl/rswkr_dp.sv
// Datapath: record memory, fill count, removal walk pointers and output register.
module rswkr_dp
    import rswkr_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  opcode_t              in_opcode,
    input  logic [FIELD_W-1:0]   in_key,
    input  logic [FIELD_W-1:0]   in_payload,
    input  rswkr_cmd_t           cmd,
    output rswkr_sts_t           sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = KEY_WIDTH + PAYLOAD_WIDTH;
    localparam int PADW = M_TDATA_W - (2 + 2 * FIELD_W + 1 + OCC_W);

    logic [RW-1:0] mem [DEPTH];
    logic [RW-1:0] rd_data_reg;

    opcode_t                  op_reg, op_next;
    logic [KEY_WIDTH-1:0]     key_reg, key_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [CW-1:0]            rd_idx_reg, rd_idx_next;
    logic [CW-1:0]            w_reg, w_next;
    logic                     pend_reg, pend_next;
    logic                     found_reg, found_next;
    status_t                  res_status_reg, res_status_next;
    logic [KEY_WIDTH-1:0]     res_key_reg, res_key_next;
    logic [PAYLOAD_WIDTH-1:0] res_pay_reg, res_pay_next;
    logic                     res_rem_reg, res_rem_next;
    logic                     m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]     m_data_reg, m_data_next;

    logic          wr_en, rd_en, issue, match;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [RW-1:0] wr_data;
    logic [CW-1:0] top_idx;

    assign top_idx = fill_reg - 1'b1;
    assign issue   = rd_idx_reg < fill_reg;
    assign match   = rd_data_reg[RW-1 -: KEY_WIDTH] == key_reg;

    assign wr_en   = cmd.push | (cmd.walk_step & pend_reg & ~match);
    assign wr_addr = cmd.push ? fill_reg[AW-1:0] : w_reg[AW-1:0];
    assign wr_data = cmd.push ? {key_reg, pay_reg} : rd_data_reg;

    assign rd_en   = cmd.rd_top | cmd.walk_start | (cmd.walk_step & issue);
    assign rd_addr = cmd.rd_top     ? top_idx[AW-1:0] :
                     cmd.walk_start ? '0 : rd_idx_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        fill_next       = fill_reg;
        rd_idx_next     = rd_idx_reg;
        w_next          = w_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        res_rem_next    = res_rem_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_data_next     = m_data_reg;

        if (cmd.capture) begin
            op_next  = in_opcode;
            key_next = in_key[KEY_WIDTH-1:0];
            pay_next = in_payload[PAYLOAD_WIDTH-1:0];
        end
        if (cmd.res_init) begin
            res_status_next = cmd.res_code;
            res_key_next    = '0;
            res_pay_next    = '0;
            res_rem_next    = 1'b0;
        end
        if (cmd.push) begin
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.take_top) begin
            res_key_next = rd_data_reg[RW-1 -: KEY_WIDTH];
            res_pay_next = rd_data_reg[PAYLOAD_WIDTH-1:0];
            if (op_reg == OP_POP) begin
                fill_next = top_idx;
            end
        end
        if (cmd.walk_start) begin
            rd_idx_next = CW'(1);
            w_next      = '0;
            pend_next   = 1'b1;
            found_next  = 1'b0;
        end
        if (cmd.walk_step) begin
            pend_next = issue;
            if (issue) begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
            if (pend_reg) begin
                if (match) begin
                    found_next = 1'b1;
                end else begin
                    w_next = w_reg + 1'b1;
                end
            end
        end
        if (cmd.walk_end) begin
            fill_next    = w_reg;
            res_rem_next = found_reg;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {{PADW{1'b0}}, OCC_W'(fill_reg), res_rem_reg,
                            FIELD_W'(res_pay_reg), FIELD_W'(res_key_reg), res_status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            w_reg       <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            w_reg       <= w_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        res_rem_reg    <= res_rem_next;
        m_data_reg     <= m_data_next;
    end

    assign sts.op        = op_reg;
    assign sts.full      = fill_reg == CW'(DEPTH);
    assign sts.empty     = fill_reg == '0;
    assign sts.walk_done = ~pend_reg;
    assign sts.out_free  = ~m_valid_reg | m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_walk_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.walk_step && pend_reg) |-> (w_reg < rd_idx_reg))
        else $error("compaction write overtook read");

    a_walk_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_end |=> (fill_reg <= $past(fill_reg)))
        else $error("removal grew the stack");

endmodule

### rtl/rswkr_ctrl.sv
// Controller state machine sequencing each operation over the datapath.
module rswkr_ctrl
    import rswkr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  rswkr_sts_t sts,
    output rswkr_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DECODE   = 5'b00010,
        S_READ_TOP = 5'b00100,
        S_WALK     = 5'b01000,
        S_FINISH   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = state_reg == S_IDLE;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.res_init = 1'b1;
                state_next   = S_FINISH;
                unique case (sts.op) inside
                    OP_PUSH: begin
                        if (sts.full) begin
                            cmd.res_code = ST_FULL;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (sts.empty) begin
                            cmd.res_code = ST_EMPTY;
                        end else begin
                            cmd.rd_top = 1'b1;
                            state_next = S_READ_TOP;
                        end
                    end
                    default: begin
                        if (sts.empty) begin
                            cmd.res_code = ST_EMPTY;
                        end else begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                endcase
            end
            S_READ_TOP: begin
                cmd.take_top = 1'b1;
                state_next   = S_FINISH;
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done) begin
                    cmd.walk_end = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/record_stack_with_key_removal.sv
// Top level: record stack with push, pop, peek and remove-by-key.
// Each transaction is accepted, decoded and finished; a pop/peek on a non-empty stack also reads the top record,
// and a remove on a non-empty stack walks the memory read port one record per cycle. One transaction at a time:
// a new one is accepted only after the last result has been loaded into the output register.
// A result may wait in the output register; the next transaction waits only if it finishes first.
// Reset (aresetn low, synchronous) empties the stack and drops any pending result.
module record_stack_with_key_removal
    import rswkr_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // opcode, record_key, record_payload
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // status, out_key, out_payload, removed_any, occupancy
);

    rswkr_cmd_t cmd;
    rswkr_sts_t sts;

    rswkr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rswkr_dp #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_opcode  (opcode_t'(s_tdata[1:0])),
        .in_key     (s_tdata[33:2]),
        .in_payload (s_tdata[65:34]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
